// ----- design/imp_pkg.sv -----
package imp_pkg;

   localparam int TERMS_PER_SECTION_DEF = 256;
   localparam int MAX_ORDER_DEF         = 6;
   localparam int FRAC_BITS_DEF         = 24;

   localparam int NUM_SECTIONS = 4;
   localparam int NUM_VARS     = 6;
   localparam int EXP_W        = 3;
   localparam int COUNT_W      = 9;
   localparam int SEC_W        = 2;
   localparam int VAR_W        = 3;
   localparam int CSR_W        = 32;

   localparam logic signed [31:0] OFFSET_FIRST_RESET = 32'sd73920;
   localparam logic signed [31:0] OFFSET_THIRD_RESET = 32'sd137120;

   localparam logic CSR_OFFSET_FIRST = 1'b0;
   localparam logic CSR_OFFSET_THIRD = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [SEC_W-1:0] SEC_FIRST = 2'd0;
   localparam logic [SEC_W-1:0] SEC_THIRD = 2'd2;
   localparam logic [SEC_W-1:0] SEC_LAST  = 2'd3;
   localparam logic [VAR_W-1:0] VAR_LAST  = 3'd5;

   typedef struct packed {
      logic                opcode;
      logic [1:0]          section;
      logic [7:0]          term_index;
      logic signed [31:0]  coefficient;
      logic [3:0]          term_order;
      logic [17:0]         exponents;
      logic signed [31:0]  x0;
      logic signed [31:0]  x1;
      logic signed [31:0]  x2;
      logic signed [31:0]  x3;
      logic signed [31:0]  x4;
      logic signed [31:0]  x5;
   } req_type;

   typedef struct packed {
      logic [1:0]          result_section;
      logic signed [31:0]  value;
      logic                saturated;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0]  coefficient;
      logic [3:0]          term_order;
      logic [17:0]         exponents;
   } term_type;

   typedef struct packed {
      logic              req_take;
      logic              sec_clear;
      logic              term_latch;
      logic              exp_shift;
      logic              pow_mul;
      logic              pow_round;
      logic              coef_mul;
      logic              coef_acc;
      logic              finish;
      logic [SEC_W-1:0]  sec;
      logic [VAR_W-1:0]  var_sel;
   } cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               exp_zero;
      logic               order_over;
   } status_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               clip;
   } sat_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > 64'sd2147483647) begin
         r.value = 32'sh7FFFFFFF;
         r.clip  = 1'b1;
      end else if (v < -64'sd2147483648) begin
         r.value = 32'sh80000000;
         r.clip  = 1'b1;
      end else begin
         r.value = v[31:0];
         r.clip  = 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- design/inverse_map_polynomial_evaluator.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    imp_pkg::req_type
// rsp       out        rsp_valid/rsp_ready    imp_pkg::rsp_type
// csr       in         csr_we (no wait)       csr_index, csr_wdata
//
// A load writes the term memory as it is taken. An evaluation walks the term
// memory with one shared 32x32 multiplier, and each response wait holds the
// walk while stalled. Synchronous reset clears the controller and term counts
// and sets the offsets to their reset values; the term memory is not cleared.
// Requests are taken only while no evaluation runs.
module inverse_map_polynomial_evaluator #(
   parameter int TERMS_PER_SECTION = imp_pkg::TERMS_PER_SECTION_DEF,
   parameter int MAX_ORDER         = imp_pkg::MAX_ORDER_DEF,
   parameter int FRAC_BITS         = imp_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  imp_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output imp_pkg::rsp_type  rsp_payload,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import imp_pkg::*;

   localparam int ADDR_W = $clog2(NUM_SECTIONS * TERMS_PER_SECTION);

   cmd_type            cmd;
   status_type         status;
   logic [ADDR_W-1:0]  rd_addr;

   imp_ctrl #(
      .TERMS_PER_SECTION (TERMS_PER_SECTION),
      .ADDR_W            (ADDR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_payload.opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   imp_dp #(
      .TERMS_PER_SECTION (TERMS_PER_SECTION),
      .MAX_ORDER         (MAX_ORDER),
      .FRAC_BITS         (FRAC_BITS),
      .ADDR_W            (ADDR_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- design/imp_ram.sv -----
module imp_ram #(
   parameter int WIDTH  = 54,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/imp_dp.sv -----
module imp_dp #(
   parameter int TERMS_PER_SECTION = 256,
   parameter int MAX_ORDER         = 6,
   parameter int FRAC_BITS         = 24,
   parameter int ADDR_W            = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  imp_pkg::req_type     req_payload,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [31:0]          csr_wdata,
   input  imp_pkg::cmd_type     cmd,
   input  logic [ADDR_W-1:0]    rd_addr,
   output imp_pkg::status_type  status,
   output imp_pkg::rsp_type     rsp_payload
);
   import imp_pkg::*;

   localparam int DEPTH = NUM_SECTIONS * TERMS_PER_SECTION;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;

   logic signed [31:0]  offset_first_ff, offset_third_ff;
   logic [COUNT_W-1:0]  count_ff [NUM_SECTIONS];
   logic signed [31:0]  x_ff [NUM_VARS];
   logic signed [31:0]  coef_ff, prod_ff;
   logic [17:0]         exps_ff;
   logic signed [63:0]  mul_ff, acc_ff;
   rsp_type             rsp_ff;

   logic                load_ok, ram_we;
   logic [ADDR_W-1:0]   wr_addr;
   term_type            wr_term, rd_term;
   logic signed [31:0]  mul_a, mul_b, offset_sel;
   logic signed [63:0]  rounded, final_sum;
   sat_type             prod_sat, final_sat;

   assign load_ok = 32'(req_payload.term_index) < TERMS_PER_SECTION;
   assign ram_we  = cmd.req_take && (req_payload.opcode == OP_LOAD) && load_ok;
   assign wr_addr = ADDR_W'(32'(req_payload.section) * TERMS_PER_SECTION
                            + 32'(req_payload.term_index));
   assign wr_term = '{coefficient: req_payload.coefficient,
                      term_order:  req_payload.term_order,
                      exponents:   req_payload.exponents};

   imp_ram #(
      .WIDTH  ($bits(term_type)),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_term_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (wr_term),
      .raddr (rd_addr),
      .rdata (rd_term)
   );

   assign mul_a     = cmd.coef_mul ? coef_ff : prod_ff;
   assign mul_b     = cmd.coef_mul ? prod_ff : x_ff[cmd.var_sel];
   assign rounded   = (mul_ff + HALF) >>> FRAC_BITS;
   assign prod_sat  = sat32(rounded);

   always_comb begin
      unique case (cmd.sec)
         SEC_FIRST: offset_sel = offset_first_ff;
         SEC_THIRD: offset_sel = offset_third_ff;
         default:   offset_sel = 32'sd0;
      endcase
   end

   assign final_sum = acc_ff - 64'(offset_sel);
   assign final_sat = sat32(final_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_first_ff <= OFFSET_FIRST_RESET;
         offset_third_ff <= OFFSET_THIRD_RESET;
         for (int i = 0; i < NUM_SECTIONS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         if (csr_we && csr_index == CSR_OFFSET_FIRST) begin
            offset_first_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_OFFSET_THIRD) begin
            offset_third_ff <= csr_wdata;
         end
         if (ram_we) begin
            count_ff[req_payload.section] <= COUNT_W'(req_payload.term_index) + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take && req_payload.opcode == OP_EVAL) begin
         x_ff[0] <= req_payload.x0;
         x_ff[1] <= req_payload.x1;
         x_ff[2] <= req_payload.x2;
         x_ff[3] <= req_payload.x3;
         x_ff[4] <= req_payload.x4;
         x_ff[5] <= req_payload.x5;
      end
      if (cmd.term_latch) begin
         coef_ff <= rd_term.coefficient;
         exps_ff <= rd_term.exponents;
         prod_ff <= ONE;
      end
      if (cmd.exp_shift) begin
         exps_ff <= exps_ff >> EXP_W;
      end
      if (cmd.pow_mul || cmd.coef_mul) begin
         mul_ff <= 64'(mul_a) * 64'(mul_b);
      end
      if (cmd.pow_round) begin
         prod_ff          <= prod_sat.value;
         exps_ff[EXP_W-1:0] <= exps_ff[EXP_W-1:0] - 1'b1;
      end
      if (cmd.sec_clear) begin
         acc_ff <= '0;
      end else if (cmd.coef_acc) begin
         acc_ff <= acc_ff + rounded;
      end
      if (cmd.finish) begin
         rsp_ff.result_section <= cmd.sec;
         rsp_ff.value          <= final_sat.value;
         rsp_ff.saturated      <= final_sat.clip;
         rsp_ff.last           <= cmd.sec == SEC_LAST;
      end
   end

   assign status.count      = count_ff[cmd.sec];
   assign status.exp_zero   = exps_ff[EXP_W-1:0] == '0;
   assign status.order_over = 32'(rd_term.term_order) > MAX_ORDER;
   assign rsp_payload       = rsp_ff;

endmodule

// ----- design/imp_ctrl.sv -----
module imp_ctrl #(
   parameter int TERMS_PER_SECTION = 256,
   parameter int ADDR_W            = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  imp_pkg::status_type  status,
   output imp_pkg::cmd_type     cmd,
   output logic [ADDR_W-1:0]    rd_addr
);
   import imp_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SEC  = 4'd1;
   localparam logic [3:0] S_READ = 4'd2;
   localparam logic [3:0] S_TERM = 4'd3;
   localparam logic [3:0] S_EXP  = 4'd4;
   localparam logic [3:0] S_PMUL = 4'd5;
   localparam logic [3:0] S_PRND = 4'd6;
   localparam logic [3:0] S_CMUL = 4'd7;
   localparam logic [3:0] S_CACC = 4'd8;
   localparam logic [3:0] S_FIN  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [SEC_W-1:0]   sec_ff, sec_in;
   logic [COUNT_W-1:0] term_ff, term_in;
   logic [VAR_W-1:0]   var_ff, var_in;
   logic               take;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   assign take      = req_valid && req_ready;
   assign rd_addr   = ADDR_W'(32'(sec_ff) * TERMS_PER_SECTION + 32'(term_ff));

   always_comb begin
      state_in = state_ff;
      sec_in   = sec_ff;
      term_in  = term_ff;
      var_in   = var_ff;
      cmd      = '0;
      cmd.req_take = take;
      cmd.sec      = sec_ff;
      cmd.var_sel  = var_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take && req_opcode == OP_EVAL) begin
               sec_in   = '0;
               state_in = S_SEC;
            end
         end
         S_SEC: begin
            cmd.sec_clear = 1'b1;
            term_in       = '0;
            state_in      = (status.count == '0) ? S_FIN : S_READ;
         end
         S_READ: state_in = S_TERM;
         S_TERM: begin
            if (status.order_over) begin
               state_in = S_FIN;
            end else begin
               cmd.term_latch = 1'b1;
               var_in         = '0;
               state_in       = S_EXP;
            end
         end
         S_EXP: begin
            if (!status.exp_zero) begin
               state_in = S_PMUL;
            end else if (var_ff == VAR_LAST) begin
               state_in = S_CMUL;
            end else begin
               cmd.exp_shift = 1'b1;
               var_in        = var_ff + 1'b1;
            end
         end
         S_PMUL: begin
            cmd.pow_mul = 1'b1;
            state_in    = S_PRND;
         end
         S_PRND: begin
            cmd.pow_round = 1'b1;
            state_in      = S_EXP;
         end
         S_CMUL: begin
            cmd.coef_mul = 1'b1;
            state_in     = S_CACC;
         end
         S_CACC: begin
            cmd.coef_acc = 1'b1;
            term_in      = term_ff + 1'b1;
            state_in     = (term_in == status.count) ? S_FIN : S_READ;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               if (sec_ff == SEC_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  sec_in   = sec_ff + 1'b1;
                  state_in = S_SEC;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sec_ff   <= '0;
         term_ff  <= '0;
         var_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sec_ff   <= sec_in;
         term_ff  <= term_in;
         var_ff   <= var_in;
      end
   end

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(sec_ff)))
      else $error("stalled response dropped");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (term_ff < status.count))
      else $error("term read past section count");

   a_last_section_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && sec_ff == SEC_LAST) |=> req_ready)
      else $error("evaluation did not finish after last response");

endmodule
